// File: src/lu_solve_3x3_unit_macros.svh
// Assertion macros used by the LU solver top level.
`ifndef LU_SOLVE_3X3_UNIT_MACROS_SVH
`define LU_SOLVE_3X3_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LSU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define LSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LSU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define LSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: src/lsu_pkg.sv
// Shared types and constants of the 3x3 LU solver.
`default_nettype none
package lsu_pkg;

  localparam int unsigned W             = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned ACC_W         = 66;
  localparam int unsigned DIV_STEPS     = W;

  localparam logic [W-1:0] SMAX = 32'h7fff_ffff;
  localparam logic [W-1:0] SMIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SINGULAR  = 2'd1,
    ST_SATURATED = 2'd2
  } status_e;

  // one lane of the restoring divider: partial remainder, dividend bits
  // shifting out on top while quotient bits shift in at the bottom
  typedef struct packed {
    logic [W:0]   rem;
    logic [W-1:0] w;
    logic         ovf;
    logic         neg;
  } div_lane_t;

  // everything an item carries down the solver pipeline
  typedef struct packed {
    logic signed [W-1:0]     a00;
    logic signed [W-1:0]     a01;
    logic signed [W-1:0]     a02;
    logic signed [W-1:0]     a11;
    logic signed [W-1:0]     a12;
    logic signed [W-1:0]     a21;
    logic signed [W-1:0]     a22;
    logic signed [W-1:0]     b0;
    logic signed [W-1:0]     b1;
    logic signed [W-1:0]     b2;
    logic signed [W-1:0]     lo10;
    logic signed [W-1:0]     lo20;
    logic signed [W-1:0]     lo21;
    logic signed [W-1:0]     up11;
    logic signed [W-1:0]     up12;
    logic signed [W-1:0]     up22;
    logic signed [W-1:0]     n21;
    logic signed [W-1:0]     y1;
    logic signed [W-1:0]     y2;
    logic signed [W-1:0]     x2;
    logic signed [W-1:0]     x1;
    logic signed [W-1:0]     n1;
    logic signed [W-1:0]     n0;
    logic signed [ACC_W-1:0] t22;
    logic signed [ACC_W-1:0] t2;
    logic signed [ACC_W-1:0] t0;
    logic                    sing;
    logic                    sat;
  } ctx_t;

endpackage
`default_nettype wire

// File: src/lu_solve_3x3_unit.sv
// Top level of the 3x3 Doolittle LU solver, fully pipelined.
// Five divider chains in series carry an item to the output register: lower factors,
// pivot row two, then the three back-substitution quotients, one quotient bit per cell.
// Throughput: one item per cycle while the skid stage is empty; it holds one result
// while the output stalls, and the input stalls until it drains.
// Reset clears all valid flags; no clearing pass, the block accepts right after reset.
`default_nettype none
`include "lu_solve_3x3_unit_macros.svh"
module lu_solve_3x3_unit #(
  parameter int unsigned FRAC_BITS = lsu_pkg::FRAC_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic signed [31:0]         m00_i,
  input  wire logic signed [31:0]         m01_i,
  input  wire logic signed [31:0]         m02_i,
  input  wire logic signed [31:0]         m10_i,
  input  wire logic signed [31:0]         m11_i,
  input  wire logic signed [31:0]         m12_i,
  input  wire logic signed [31:0]         m20_i,
  input  wire logic signed [31:0]         m21_i,
  input  wire logic signed [31:0]         m22_i,
  input  wire logic signed [31:0]         rhs0_i,
  input  wire logic signed [31:0]         rhs1_i,
  input  wire logic signed [31:0]         rhs2_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic signed [31:0]              sol0_o,
  output logic signed [31:0]              sol1_o,
  output logic signed [31:0]              sol2_o,
  output logic [1:0]                      status_o
);

  localparam int unsigned W  = lsu_pkg::W;
  localparam int unsigned AW = lsu_pkg::ACC_W;
  localparam int unsigned CW = $bits(lsu_pkg::ctx_t);

  typedef logic signed [AW-1:0] acc_t;

  typedef struct packed {
    logic [W-1:0]     sol0;
    logic [W-1:0]     sol1;
    logic [W-1:0]     sol2;
    lsu_pkg::status_e status;
  } res_t;

  function automatic acc_t ext(input logic signed [W-1:0] v);
    return {{(AW-W){v[W-1]}}, v};
  endfunction

  // round half up, then floor shift
  function automatic acc_t rnd(input logic signed [63:0] p);
    acc_t e;
    e = {{(AW-64){p[63]}}, p};
    return (e + (acc_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  // flag in the top bit, clamped value below
  function automatic logic [W:0] sat32(input acc_t v);
    if ((v[AW-1:W-1] == '0) || (v[AW-1:W-1] == '1)) begin
      return {1'b0, v[W-1:0]};
    end
    return {1'b1, v[AW-1] ? lsu_pkg::SMIN : lsu_pkg::SMAX};
  endfunction

  logic en;
  logic out_v_q, skid_v_q, take;
  res_t out_r_q, skid_r_q, pr;
  logic pv;

  // input stage
  logic          v0_q;
  lsu_pkg::ctx_t c0_d, c0_q;
  logic [W-1:0]  n10_q, n20_q;

  // lower factors of column zero
  logic                d1_v;
  logic [1:0][W-1:0]   d1_num, d1_q;
  logic [1:0]          d1_s;
  logic [CW-1:0]       d1_pay;
  lsu_pkg::ctx_t       m1_d, m1_c_q;
  logic                m1_v_q;
  logic signed [63:0]  m1_p_q [0:5];
  lsu_pkg::ctx_t       s1_d, s1_c_q;
  logic                s1_v_q;
  logic [W:0]          r_up11, r_up12, r_n21, r_y1;

  // lower factor of row two
  logic                d2_v;
  logic [0:0][W-1:0]   d2_q;
  logic [0:0]          d2_s;
  logic [CW-1:0]       d2_pay;
  lsu_pkg::ctx_t       m2_d, m2_c_q;
  logic                m2_v_q;
  logic signed [63:0]  m2_p_q [0:1];
  lsu_pkg::ctx_t       s2_d, s2_c_q;
  logic                s2_v_q;
  logic [W:0]          r_up22, r_y2;

  // unknown two
  logic                d3_v;
  logic [0:0][W-1:0]   d3_q;
  logic [0:0]          d3_s;
  logic [CW-1:0]       d3_pay;
  lsu_pkg::ctx_t       m3_d, m3_c_q;
  logic                m3_v_q;
  logic signed [63:0]  m3_p_q [0:1];
  lsu_pkg::ctx_t       s3_d, s3_c_q;
  logic                s3_v_q;
  logic [W:0]          r_n1;

  // unknown one
  logic                d4_v;
  logic [0:0][W-1:0]   d4_q;
  logic [0:0]          d4_s;
  logic [CW-1:0]       d4_pay;
  lsu_pkg::ctx_t       m4_d, m4_c_q;
  logic                m4_v_q;
  logic signed [63:0]  m4_p_q;
  lsu_pkg::ctx_t       s4_d, s4_c_q;
  logic                s4_v_q;
  logic [W:0]          r_n0;

  // unknown zero
  logic                d5_v;
  logic [0:0][W-1:0]   d5_q;
  logic [0:0]          d5_s;
  logic [CW-1:0]       d5_pay;
  lsu_pkg::ctx_t       f_c;

  // pipeline runs unless the skid stage is occupied
  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  always_comb begin
    c0_d      = '0;
    c0_d.a00  = m00_i;
    c0_d.a01  = m01_i;
    c0_d.a02  = m02_i;
    c0_d.a11  = m11_i;
    c0_d.a12  = m12_i;
    c0_d.a21  = m21_i;
    c0_d.a22  = m22_i;
    c0_d.b0   = rhs0_i;
    c0_d.b1   = rhs1_i;
    c0_d.b2   = rhs2_i;
    c0_d.sing = (m00_i == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      m1_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      m3_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      m4_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else if (en) begin
      v0_q   <= in_valid_i;
      m1_v_q <= d1_v;
      s1_v_q <= m1_v_q;
      m2_v_q <= d2_v;
      s2_v_q <= m2_v_q;
      m3_v_q <= d3_v;
      s3_v_q <= m3_v_q;
      m4_v_q <= d4_v;
      s4_v_q <= m4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c0_q  <= c0_d;
      n10_q <= m10_i;
      n20_q <= m20_i;
    end
  end

  assign d1_num[0] = n10_q;
  assign d1_num[1] = n20_q;

  lsu_div #(
    .FRAC_BITS(FRAC_BITS),
    .LANES    (2),
    .PW       (CW)
  ) u_div_l0 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(v0_q),
    .num_i  (d1_num),
    .den_i  (c0_q.a00),
    .pay_i  (c0_q),
    .valid_o(d1_v),
    .quo_o  (d1_q),
    .sat_o  (d1_s),
    .pay_o  (d1_pay)
  );

  always_comb begin
    m1_d      = lsu_pkg::ctx_t'(d1_pay);
    m1_d.lo10 = d1_q[0];
    m1_d.lo20 = d1_q[1];
    m1_d.sat  = m1_d.sat | (|d1_s);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_c_q    <= m1_d;
      m1_p_q[0] <= $signed(m1_d.lo10) * $signed(m1_d.a01);
      m1_p_q[1] <= $signed(m1_d.lo10) * $signed(m1_d.a02);
      m1_p_q[2] <= $signed(m1_d.lo20) * $signed(m1_d.a01);
      m1_p_q[3] <= $signed(m1_d.lo20) * $signed(m1_d.a02);
      m1_p_q[4] <= $signed(m1_d.lo10) * $signed(m1_d.b0);
      m1_p_q[5] <= $signed(m1_d.lo20) * $signed(m1_d.b0);
    end
  end

  always_comb begin
    s1_d      = m1_c_q;
    r_up11    = sat32(ext(m1_c_q.a11) - rnd(m1_p_q[0]));
    r_up12    = sat32(ext(m1_c_q.a12) - rnd(m1_p_q[1]));
    r_n21     = sat32(ext(m1_c_q.a21) - rnd(m1_p_q[2]));
    r_y1      = sat32(ext(m1_c_q.b1) - rnd(m1_p_q[4]));
    s1_d.up11 = r_up11[W-1:0];
    s1_d.up12 = r_up12[W-1:0];
    s1_d.n21  = r_n21[W-1:0];
    s1_d.y1   = r_y1[W-1:0];
    s1_d.t22  = ext(m1_c_q.a22) - rnd(m1_p_q[3]);
    s1_d.t2   = ext(m1_c_q.b2) - rnd(m1_p_q[5]);
    s1_d.sing = m1_c_q.sing | (r_up11[W-1:0] == '0);
    s1_d.sat  = m1_c_q.sat | r_up11[W] | r_up12[W] | r_n21[W] | r_y1[W];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_c_q <= s1_d;
    end
  end

  lsu_div #(
    .FRAC_BITS(FRAC_BITS),
    .LANES    (1),
    .PW       (CW)
  ) u_div_l21 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s1_v_q),
    .num_i  (s1_c_q.n21),
    .den_i  (s1_c_q.up11),
    .pay_i  (s1_c_q),
    .valid_o(d2_v),
    .quo_o  (d2_q),
    .sat_o  (d2_s),
    .pay_o  (d2_pay)
  );

  always_comb begin
    m2_d      = lsu_pkg::ctx_t'(d2_pay);
    m2_d.lo21 = d2_q[0];
    m2_d.sat  = m2_d.sat | d2_s[0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_c_q    <= m2_d;
      m2_p_q[0] <= $signed(m2_d.lo21) * $signed(m2_d.up12);
      m2_p_q[1] <= $signed(m2_d.lo21) * $signed(m2_d.y1);
    end
  end

  always_comb begin
    s2_d      = m2_c_q;
    r_up22    = sat32(m2_c_q.t22 - rnd(m2_p_q[0]));
    r_y2      = sat32(m2_c_q.t2 - rnd(m2_p_q[1]));
    s2_d.up22 = r_up22[W-1:0];
    s2_d.y2   = r_y2[W-1:0];
    s2_d.sing = m2_c_q.sing | (r_up22[W-1:0] == '0);
    s2_d.sat  = m2_c_q.sat | r_up22[W] | r_y2[W];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_c_q <= s2_d;
    end
  end

  lsu_div #(
    .FRAC_BITS(FRAC_BITS),
    .LANES    (1),
    .PW       (CW)
  ) u_div_x2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s2_v_q),
    .num_i  (s2_c_q.y2),
    .den_i  (s2_c_q.up22),
    .pay_i  (s2_c_q),
    .valid_o(d3_v),
    .quo_o  (d3_q),
    .sat_o  (d3_s),
    .pay_o  (d3_pay)
  );

  always_comb begin
    m3_d     = lsu_pkg::ctx_t'(d3_pay);
    m3_d.x2  = d3_q[0];
    m3_d.sat = m3_d.sat | d3_s[0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m3_c_q    <= m3_d;
      m3_p_q[0] <= $signed(m3_d.up12) * $signed(m3_d.x2);
      m3_p_q[1] <= $signed(m3_d.a02) * $signed(m3_d.x2);
    end
  end

  always_comb begin
    s3_d     = m3_c_q;
    r_n1     = sat32(ext(m3_c_q.y1) - rnd(m3_p_q[0]));
    s3_d.n1  = r_n1[W-1:0];
    s3_d.t0  = ext(m3_c_q.b0) - rnd(m3_p_q[1]);
    s3_d.sat = m3_c_q.sat | r_n1[W];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_c_q <= s3_d;
    end
  end

  lsu_div #(
    .FRAC_BITS(FRAC_BITS),
    .LANES    (1),
    .PW       (CW)
  ) u_div_x1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s3_v_q),
    .num_i  (s3_c_q.n1),
    .den_i  (s3_c_q.up11),
    .pay_i  (s3_c_q),
    .valid_o(d4_v),
    .quo_o  (d4_q),
    .sat_o  (d4_s),
    .pay_o  (d4_pay)
  );

  always_comb begin
    m4_d     = lsu_pkg::ctx_t'(d4_pay);
    m4_d.x1  = d4_q[0];
    m4_d.sat = m4_d.sat | d4_s[0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m4_c_q <= m4_d;
      m4_p_q <= $signed(m4_d.a01) * $signed(m4_d.x1);
    end
  end

  always_comb begin
    s4_d     = m4_c_q;
    r_n0     = sat32(m4_c_q.t0 - rnd(m4_p_q));
    s4_d.n0  = r_n0[W-1:0];
    s4_d.sat = m4_c_q.sat | r_n0[W];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_c_q <= s4_d;
    end
  end

  lsu_div #(
    .FRAC_BITS(FRAC_BITS),
    .LANES    (1),
    .PW       (CW)
  ) u_div_x0 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s4_v_q),
    .num_i  (s4_c_q.n0),
    .den_i  (s4_c_q.a00),
    .pay_i  (s4_c_q),
    .valid_o(d5_v),
    .quo_o  (d5_q),
    .sat_o  (d5_s),
    .pay_o  (d5_pay)
  );

  // zero pivot wins over saturation
  always_comb begin
    f_c = lsu_pkg::ctx_t'(d5_pay);
    pv  = d5_v;
    if (f_c.sing) begin
      pr.sol0   = '0;
      pr.sol1   = '0;
      pr.sol2   = '0;
      pr.status = lsu_pkg::ST_SINGULAR;
    end else begin
      pr.sol0   = d5_q[0];
      pr.sol1   = f_c.x1;
      pr.sol2   = f_c.x2;
      pr.status = (f_c.sat | d5_s[0]) ? lsu_pkg::ST_SATURATED : lsu_pkg::ST_OK;
    end
  end

  // output register plus one skid entry
  assign take = !out_v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (take) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end
    end else if (take) begin
      out_v_q <= pv;
    end else if (pv) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (take) begin
        out_r_q <= skid_r_q;
      end
    end else if (take) begin
      out_r_q <= pr;
    end else if (pv) begin
      skid_r_q <= pr;
    end
  end

  assign out_valid_o = out_v_q;
  assign sol0_o      = out_r_q.sol0;
  assign sol1_o      = out_r_q.sol1;
  assign sol2_o      = out_r_q.sol2;
  assign status_o    = out_r_q.status;

  `LSU_ASSERT_IMPL(a_skid_needs_out, clk_i, rst_ni, skid_v_q, out_v_q, "skid item with empty output")
  `LSU_ASSERT_NEXT(a_skid_drains, clk_i, rst_ni, skid_v_q && !out_stall_i, !skid_v_q, "skid not drained")
  `LSU_ASSERT_NEXT(a_freeze, clk_i, rst_ni, skid_v_q, $stable(v0_q) && $stable(s4_v_q), "pipe moved while frozen")
  `LSU_ASSERT_IMPL(a_sing_zero, clk_i, rst_ni, out_v_q && out_r_q.status == lsu_pkg::ST_SINGULAR, out_r_q.sol0 == '0 && out_r_q.sol1 == '0 && out_r_q.sol2 == '0, "singular result not zero")

endmodule
`default_nettype wire

// File: src/lsu_div_cell.sv
// One quotient bit of the pipelined restoring divider.
`default_nettype none
module lsu_div_cell #(
  parameter int unsigned LANES = 1,
  parameter int unsigned PW    = 1
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                en_i,
  input  wire logic                                valid_i,
  input  wire logic [lsu_pkg::W-1:0]               md_i,
  input  wire lsu_pkg::div_lane_t [LANES-1:0]      lane_i,
  input  wire logic [PW-1:0]                       pay_i,
  output logic                                     valid_o,
  output logic [lsu_pkg::W-1:0]                    md_o,
  output lsu_pkg::div_lane_t [LANES-1:0]           lane_o,
  output logic [PW-1:0]                            pay_o
);

  lsu_pkg::div_lane_t [LANES-1:0] lane_d;
  logic [lsu_pkg::W:0]            part [LANES];
  logic [LANES-1:0]               ge;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      // bring down the next dividend bit
      part[l] = {lane_i[l].rem[lsu_pkg::W-1:0], lane_i[l].w[lsu_pkg::W-1]};
      ge[l]   = part[l] >= {1'b0, md_i};
      lane_d[l].rem = ge[l] ? (part[l] - {1'b0, md_i}) : part[l];
      lane_d[l].w   = {lane_i[l].w[lsu_pkg::W-2:0], ge[l]};
      lane_d[l].ovf = lane_i[l].ovf;
      lane_d[l].neg = lane_i[l].neg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      md_o   <= md_i;
      lane_o <= lane_d;
      pay_o  <= pay_i;
    end
  end

endmodule
`default_nettype wire

// File: src/lsu_div.sv
// Pipelined rounding Q-format divider: a chain of one-bit cells with sign handling.
`default_nettype none
module lsu_div #(
  parameter int unsigned FRAC_BITS = lsu_pkg::FRAC_BITS_DEF,
  parameter int unsigned LANES     = 1,
  parameter int unsigned PW        = 1
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                en_i,
  input  wire logic                                valid_i,
  input  wire logic [LANES-1:0][lsu_pkg::W-1:0]    num_i,
  input  wire logic [lsu_pkg::W-1:0]               den_i,
  input  wire logic [PW-1:0]                       pay_i,
  output logic                                     valid_o,
  output logic [LANES-1:0][lsu_pkg::W-1:0]         quo_o,
  output logic [LANES-1:0]                         sat_o,
  output logic [PW-1:0]                            pay_o
);

  localparam int unsigned W  = lsu_pkg::W;
  localparam int unsigned DW = W + FRAC_BITS + 1;
  localparam int unsigned NS = lsu_pkg::DIV_STEPS;

  // magnitudes and signs
  logic                        p1_v_q;
  logic [LANES-1:0][W-1:0]     p1_mn_q;
  logic [W-1:0]                p1_md_q;
  logic [LANES-1:0]            p1_neg_q;
  logic [PW-1:0]               p1_pay_q;
  // scaled dividend plus half the divisor
  logic                        p2_v_q;
  logic [LANES-1:0][DW-1:0]    p2_dd_q;
  logic [W-1:0]                p2_md_q;
  logic [LANES-1:0]            p2_neg_q;
  logic [PW-1:0]               p2_pay_q;
  // initial remainder and overflow check
  logic                        p3_v_q;
  lsu_pkg::div_lane_t [LANES-1:0] p3_lane_q;
  logic [W-1:0]                p3_md_q;
  logic [PW-1:0]               p3_pay_q;

  logic                           ch_v    [0:NS];
  logic [W-1:0]                   ch_md   [0:NS];
  lsu_pkg::div_lane_t [LANES-1:0] ch_lane [0:NS];
  logic [PW-1:0]                  ch_pay  [0:NS];

  logic [LANES-1:0][W-1:0] quo_d;
  logic [LANES-1:0]        sat_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      p3_v_q  <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      p1_v_q  <= valid_i;
      p2_v_q  <= p1_v_q;
      p3_v_q  <= p2_v_q;
      valid_o <= ch_v[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < LANES; l++) begin
        p1_mn_q[l]  <= num_i[l][W-1] ? (W'(0) - num_i[l]) : num_i[l];
        p1_neg_q[l] <= num_i[l][W-1] ^ den_i[W-1];
        p2_dd_q[l]  <= {1'b0, p1_mn_q[l], {FRAC_BITS{1'b0}}} + DW'(p1_md_q[W-1:1]);
        p2_neg_q[l] <= p1_neg_q[l];
        p3_lane_q[l].rem <= (W+1)'(p2_dd_q[l][DW-1:W]);
        p3_lane_q[l].w   <= p2_dd_q[l][W-1:0];
        p3_lane_q[l].ovf <= (W+1)'(p2_dd_q[l][DW-1:W]) >= {1'b0, p2_md_q};
        p3_lane_q[l].neg <= p2_neg_q[l];
      end
      p1_md_q  <= den_i[W-1] ? (W'(0) - den_i) : den_i;
      p1_pay_q <= pay_i;
      p2_md_q  <= p1_md_q;
      p2_pay_q <= p1_pay_q;
      p3_md_q  <= p2_md_q;
      p3_pay_q <= p2_pay_q;
      quo_o    <= quo_d;
      sat_o    <= sat_d;
      pay_o    <= ch_pay[NS];
    end
  end

  assign ch_v[0]    = p3_v_q;
  assign ch_md[0]   = p3_md_q;
  assign ch_lane[0] = p3_lane_q;
  assign ch_pay[0]  = p3_pay_q;

  for (genvar gi = 0; gi < NS; gi++) begin : g_step
    lsu_div_cell #(
      .LANES(LANES),
      .PW   (PW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .valid_i(ch_v[gi]),
      .md_i   (ch_md[gi]),
      .lane_i (ch_lane[gi]),
      .pay_i  (ch_pay[gi]),
      .valid_o(ch_v[gi+1]),
      .md_o   (ch_md[gi+1]),
      .lane_o (ch_lane[gi+1]),
      .pay_o  (ch_pay[gi+1])
    );
  end

  // apply sign, clamp to the signed 32-bit range
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sat_d[l] = ch_lane[NS][l].ovf
               | (!ch_lane[NS][l].neg && ch_lane[NS][l].w[W-1])
               | (ch_lane[NS][l].neg && ch_lane[NS][l].w[W-1]
                  && (ch_lane[NS][l].w[W-2:0] != '0));
      if (sat_d[l]) begin
        quo_d[l] = ch_lane[NS][l].neg ? lsu_pkg::SMIN : lsu_pkg::SMAX;
      end else if (ch_lane[NS][l].neg) begin
        quo_d[l] = W'(0) - ch_lane[NS][l].w;
      end else begin
        quo_d[l] = ch_lane[NS][l].w;
      end
    end
  end

endmodule
`default_nettype wire

// File: verif/lu_solve_3x3_unit_tb.sv
// Self-checking testbench for the 3x3 LU solver: directed and random traffic against a built-in predictor.
`timescale 1ns / 100ps
`default_nettype none
module lu_solve_3x3_unit_tb;

  localparam int FB = 16;
  localparam int N_RANDOM = 600;
  localparam int DRAIN_CYCLES = 400;

  typedef struct packed {
    logic signed [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [31:0] r0, r1, r2;
  } system_t;

  typedef struct packed {
    logic signed [31:0] s0, s1, s2;
    logic [1:0]         st;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_stall_i = 1'b0;
  logic in_stall_o, out_valid_o;
  logic signed [31:0] m00_i = '0, m01_i = '0, m02_i = '0, m10_i = '0, m11_i = '0,
                      m12_i = '0, m20_i = '0, m21_i = '0, m22_i = '0;
  logic signed [31:0] rhs0_i = '0, rhs1_i = '0, rhs2_i = '0;
  logic signed [31:0] sol0_o, sol1_o, sol2_o;
  logic [1:0]         status_o;

  system_t pending_systems[$];
  answer_t expected_answers[$];
  int n_accepted = 0, n_checked = 0, n_mismatch = 0;
  int n_singular = 0, n_saturated = 0;
  bit stimulus_done = 1'b0;
  bit calm = 1'b0;
  int in_gap = 0, out_gap = 0;

  lu_solve_3x3_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .m00_i(m00_i), .m01_i(m01_i), .m02_i(m02_i),
    .m10_i(m10_i), .m11_i(m11_i), .m12_i(m12_i),
    .m20_i(m20_i), .m21_i(m21_i), .m22_i(m22_i),
    .rhs0_i(rhs0_i), .rhs1_i(rhs1_i), .rhs2_i(rhs2_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .sol0_o(sol0_o), .sol1_o(sol1_o), .sol2_o(sol2_o), .status_o(status_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------- predictor ----------------
  bit sat_flag;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) begin
      sat_flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat_flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // rounded fixed-point product, round half up (arithmetic shift is a floor)
  function automatic longint fx_mul(longint a, longint b);
    logic signed [127:0] p;
    p = 128'(a) * 128'(b) + (128'sd1 <<< (FB - 1));
    return longint'(p >>> FB);
  endfunction

  // quotient rounded to nearest, ties away from zero
  function automatic longint fx_div(longint n, longint d);
    longint num, q;
    longint unsigned mn, md;
    num = n * (64'sd1 <<< FB);
    mn = (num < 0) ? longint'(-num) : num;
    md = (d < 0) ? longint'(-d) : d;
    q = longint'((mn + md / 2) / md);
    if ((num < 0) != (d < 0)) q = -q;
    return clamp32(q);
  endfunction

  function automatic answer_t solve_system(system_t s);
    longint a[3][3], lo[3][3], up[3][3], b[3], y[3], x[3];
    longint acc;
    int lim;
    bit singular;
    answer_t r;
    sat_flag = 1'b0;
    singular = 1'b0;
    a[0] = '{s.m00, s.m01, s.m02};
    a[1] = '{s.m10, s.m11, s.m12};
    a[2] = '{s.m20, s.m21, s.m22};
    b = '{s.r0, s.r1, s.r2};
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        lo[i][j] = (i == j) ? (64'sd1 <<< FB) : 0;
        up[i][j] = 0;
      end
    for (int i = 0; i < 3 && !singular; i++) begin
      for (int j = 0; j < 3; j++) begin
        lim = (i < j) ? i : j;
        acc = a[i][j];
        for (int k = 0; k < lim; k++) acc -= fx_mul(lo[i][k], up[k][j]);
        acc = clamp32(acc);
        if (i <= j) up[i][j] = acc;
        else lo[i][j] = fx_div(acc, up[j][j]);
      end
      if (up[i][i] == 0) singular = 1'b1;
    end
    if (singular) begin
      r.s0 = '0; r.s1 = '0; r.s2 = '0;
      r.st = lsu_pkg::ST_SINGULAR;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      acc = b[i];
      for (int j = 0; j < i; j++) acc -= fx_mul(lo[i][j], y[j]);
      y[i] = clamp32(acc);
    end
    for (int i = 2; i >= 0; i--) begin
      acc = y[i];
      for (int j = i + 1; j < 3; j++) acc -= fx_mul(up[i][j], x[j]);
      x[i] = fx_div(clamp32(acc), up[i][i]);
    end
    r.s0 = x[0][31:0]; r.s1 = x[1][31:0]; r.s2 = x[2][31:0];
    r.st = sat_flag ? lsu_pkg::ST_SATURATED : lsu_pkg::ST_OK;
    return r;
  endfunction

  // ---------------- stimulus ----------------
  function automatic logic [31:0] rand_entry(int mode);
    logic [31:0] v;
    case (mode)
      0: v = $urandom;
      1: v = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      2: v = $urandom_range(0, 5) == 0 ? 32'h7fff_ffff : 32'h8000_0000;
      default: v = ($urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000) *
                   $urandom_range(0, 8);
    endcase
    return v;
  endfunction

  function automatic system_t rand_system();
    system_t s;
    int mode;
    logic [383:0] bits;
    mode = $urandom_range(0, 9);
    for (int f = 0; f < 12; f++) begin
      if (mode < 2) bits[f*32 +: 32] = rand_entry(0);
      else if (mode < 7) bits[f*32 +: 32] = rand_entry(1);
      else if (mode == 7) bits[f*32 +: 32] = rand_entry($urandom_range(0, 3));
      else bits[f*32 +: 32] = rand_entry(3);
    end
    s = bits;
    // strengthen the diagonal on some well-conditioned systems
    if (mode >= 2 && mode < 5) begin
      s.m00 = s.m00 + 32'sh0008_0000;
      s.m11 = s.m11 + 32'sh0008_0000;
      s.m22 = s.m22 + 32'sh0008_0000;
    end
    return s;
  endfunction

  function automatic system_t diag_system(logic signed [31:0] d0, logic signed [31:0] d1,
                                          logic signed [31:0] d2, logic signed [31:0] r);
    system_t s;
    s = '0;
    s.m00 = d0; s.m11 = d1; s.m22 = d2;
    s.r0 = r; s.r1 = -r; s.r2 = r;
    return s;
  endfunction

  initial begin
    system_t s;
    localparam logic signed [31:0] ONE = 32'sh0001_0000;
    pending_systems.push_back(diag_system(ONE, ONE, ONE, ONE));          // identity
    pending_systems.push_back(diag_system(ONE, ONE, ONE, lsu_pkg::SMAX));
    pending_systems.push_back(diag_system(ONE, ONE, ONE, lsu_pkg::SMIN));
    pending_systems.push_back(diag_system('0, ONE, ONE, ONE));           // first pivot zero
    pending_systems.push_back(diag_system(ONE, '0, ONE, ONE));           // middle pivot zero
    pending_systems.push_back(diag_system(ONE, ONE, '0, ONE));           // last pivot zero
    pending_systems.push_back(diag_system(32'sd1, 32'sd1, 32'sd1, lsu_pkg::SMAX)); // quotient saturates
    pending_systems.push_back(diag_system(lsu_pkg::SMIN, lsu_pkg::SMIN, lsu_pkg::SMIN,
                                          lsu_pkg::SMIN));
    pending_systems.push_back(diag_system(lsu_pkg::SMAX, lsu_pkg::SMAX, lsu_pkg::SMAX,
                                          lsu_pkg::SMIN));
    pending_systems.push_back(diag_system(-ONE, -ONE, -ONE, 32'sd3));
    pending_systems.push_back(diag_system(32'sd3, -32'sd3, 32'sd2, 32'sd1)); // pivots of 3, -3 and 2 ulp
    s = '1; pending_systems.push_back(s);                                // all -ulp
    s = '0; pending_systems.push_back(s);                                // all zero
    s = {12{32'h7fff_ffff}}; pending_systems.push_back(s);
    s = {12{32'h8000_0000}}; pending_systems.push_back(s);
    // systems that need elimination; the first cancels to a zero pivot
    s = diag_system(ONE, ONE, ONE, ONE);
    s.m01 = ONE; s.m10 = ONE;
    pending_systems.push_back(s);
    s = '0;
    s.m00 = 32'sh0002_0000; s.m01 = ONE; s.m02 = ONE;
    s.m10 = 32'sh0004_0000; s.m11 = 32'sh0003_0000; s.m12 = 32'sh0003_0000;
    s.m20 = 32'sh0008_0000; s.m21 = 32'sh0007_0000; s.m22 = 32'sh0009_0000;
    s.r0 = ONE; s.r1 = -ONE; s.r2 = 32'sh0000_8000;
    pending_systems.push_back(s);
    // intermediate overflow with nonzero pivots
    s = {12{32'h7fff_0000}}; s.m11 = lsu_pkg::SMIN; s.m22 = ONE;
    pending_systems.push_back(s);
    for (int n = 0; n < N_RANDOM; n++) pending_systems.push_back(rand_system());
  end

  // ---------------- driver ----------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_answers.push_back(solve_system({m00_i, m01_i, m02_i, m10_i, m11_i, m12_i,
                                                 m20_i, m21_i, m22_i, rhs0_i, rhs1_i,
                                                 rhs2_i}));
        n_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        // the current item is gone (or none was shown): pick the next or idle
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (!calm && $urandom_range(0, 15) == 0) begin
          in_gap = $urandom_range(1, 10) - 1;
          in_valid_i <= 1'b0;
        end else if (pending_systems.size() > 0) begin
          s_drive(pending_systems.pop_front());
        end else begin
          in_valid_i <= 1'b0;
          stimulus_done = 1'b1;
        end
      end
    end
  end

  task automatic s_drive(system_t s);
    in_valid_i <= 1'b1;
    m00_i <= s.m00; m01_i <= s.m01; m02_i <= s.m02;
    m10_i <= s.m10; m11_i <= s.m11; m12_i <= s.m12;
    m20_i <= s.m20; m21_i <= s.m21; m22_i <= s.m22;
    rhs0_i <= s.r0; rhs1_i <= s.r1; rhs2_i <= s.r2;
  endtask

  // ---------------- monitor ----------------
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_answers.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected result: sol %h %h %h status %0d",
                                         sol0_o, sol1_o, sol2_o, status_o);
        end else begin
          want = expected_answers.pop_front();
          n_checked++;
          if (want.st == lsu_pkg::ST_SINGULAR) n_singular++;
          if (want.st == lsu_pkg::ST_SATURATED) n_saturated++;
          if (sol0_o !== want.s0 || sol1_o !== want.s1 || sol2_o !== want.s2 ||
              status_o !== want.st) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("result %0d mismatch: expected %h %h %h st %0d, got %h %h %h st %0d",
                       n_checked - 1, want.s0, want.s1, want.s2, want.st,
                       sol0_o, sol1_o, sol2_o, status_o);
          end
        end
      end
      // receiver stalls in bursts
      if (out_gap > 0) begin
        out_gap--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        out_gap = $urandom_range(1, 10) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------- sequencing ----------------
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_systems.size() > 0 && pending_systems.size() < 80);
    calm = 1'b1;
    wait (stimulus_done && expected_answers.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_answers.size() != 0) n_mismatch++;
    $display("sent %0d systems, checked %0d results (%0d singular, %0d saturated)",
             n_accepted, n_checked, n_singular, n_saturated);
    $display("%0d mismatches", n_mismatch);
    if (n_mismatch == 0) begin
      $display("** lu_solve_3x3_unit: PASSED **");
    end else begin
      $display("** lu_solve_3x3_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout waiting for results");
    $display("** lu_solve_3x3_unit: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
+incdir+src
src/lsu_pkg.sv
src/lsu_div_cell.sv
src/lsu_div.sv
src/lu_solve_3x3_unit.sv
verif/lu_solve_3x3_unit_tb.sv
